// File: rtl/msp_pkg.sv
// Shared types and constants of the SUBACK packet parser.
package msp_pkg;

  // Default upper bound on granted codes per packet, on top of the register.
  localparam int unsigned CodeCountLimitDef = 255;

  // Reset value of the max_codes register.
  localparam logic [7:0] MaxCodesReset = 8'd255;

  // Upper nibble of the fixed header byte of a SUBACK.
  localparam logic [3:0] SubackType = 4'h9;

  typedef enum logic [1:0] {
    KindCode = 2'd0,
    KindDone = 2'd1,
    KindErr  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusWrongType = 3'd1,
    StatusTooMany   = 3'd2,
    StatusLenShort  = 3'd3,
    StatusLenMalf   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic        has_code;
    logic [7:0]  code_value;
    logic [7:0]  code_index;
    status_e     status;
    logic [15:0] packet_ident;
    logic [7:0]  code_count;
  } result_t;

endpackage

// File: rtl/msp_if.sv
// Stream interfaces of the SUBACK parser: input bytes, results and configuration.
interface msp_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       packet_start;

  modport source (output valid, output rx_byte, output packet_start, input ready);
  modport sink (input valid, input rx_byte, input packet_start, output ready);
endinterface

interface msp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        has_code;
  logic [7:0]  code_value;
  logic [7:0]  code_index;
  logic [2:0]  status;
  logic [15:0] packet_ident;
  logic [7:0]  code_count;

  modport source (output valid, output kind, output has_code, output code_value,
                  output code_index, output status, output packet_ident,
                  output code_count, input ready);
  modport sink (input valid, input kind, input has_code, input code_value,
                input code_index, input status, input packet_ident,
                input code_count, output ready);
endinterface

interface msp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_codes;

  modport source (output valid, output max_codes, input ready);
  modport sink (input valid, input max_codes, output ready);
endinterface

// File: rtl/msp_parse.sv
// Parser state and the per-byte next-state and result logic.
module msp_parse #(
  parameter int unsigned CodeCountLimit = msp_pkg::CodeCountLimitDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  msp_pkg::item_t   item_i,
  input  logic [7:0]       max_codes_i,
  output logic             res_vld_o,
  output msp_pkg::result_t res_o
);

  localparam int unsigned CapLimit = (CodeCountLimit > 255) ? 255 : CodeCountLimit;
  localparam logic [7:0] CapLimitB = 8'(CapLimit);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhLen   = 3'd1,
    PhIdh   = 3'd2,
    PhIdl   = 3'd3,
    PhCodes = 3'd4,
    PhDone  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [27:0] bytes_left_q, bytes_left_d;
  logic [1:0]  len_num_q, len_num_d;
  logic [15:0] ident_q, ident_d;
  logic        ident_vld_q, ident_vld_d;
  logic [7:0]  codes_seen_q, codes_seen_d;

  logic [7:0]  limit;
  logic [27:0] len_group;
  logic [27:0] len_acc;
  logic [27:0] bytes_dec;
  logic [7:0]  b;

  assign b         = item_i.rx_byte;
  assign limit     = (max_codes_i < CapLimitB) ? max_codes_i : CapLimitB;
  assign bytes_dec = bytes_left_q - 28'd1;

  // Length bytes carry seven bits each, least significant group first.
  always_comb begin
    case (len_num_q)
      2'd0:    len_group = {21'd0, b[6:0]};
      2'd1:    len_group = {14'd0, b[6:0], 7'd0};
      2'd2:    len_group = {7'd0, b[6:0], 14'd0};
      default: len_group = {b[6:0], 21'd0};
    endcase
  end

  assign len_acc = bytes_left_q | len_group;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    len_num_d    = len_num_q;
    ident_d      = ident_q;
    ident_vld_d  = ident_vld_q;
    codes_seen_d = codes_seen_q;
    res_vld_o    = 1'b0;
    res_o        = '0;

    if (item_i.packet_start) begin
      bytes_left_d = '0;
      len_num_d    = '0;
      ident_d      = '0;
      ident_vld_d  = 1'b0;
      codes_seen_d = '0;
      if (b[7:4] != msp_pkg::SubackType) begin
        phase_d      = PhDone;
        res_vld_o    = 1'b1;
        res_o.kind   = msp_pkg::KindErr;
        res_o.status = msp_pkg::StatusWrongType;
      end else begin
        phase_d = PhLen;
      end
    end else begin
      case (phase_q)
        PhLen: begin
          bytes_left_d = len_acc;
          if (b[7]) begin
            if (len_num_q == 2'd3) begin
              phase_d      = PhDone;
              res_vld_o    = 1'b1;
              res_o.kind   = msp_pkg::KindErr;
              res_o.status = msp_pkg::StatusLenMalf;
            end else begin
              len_num_d = len_num_q + 2'd1;
            end
          end else if (len_acc < 28'd2) begin
            phase_d      = PhDone;
            res_vld_o    = 1'b1;
            res_o.kind   = msp_pkg::KindErr;
            res_o.status = msp_pkg::StatusLenShort;
          end else begin
            phase_d = PhIdh;
          end
        end
        PhIdh: begin
          ident_d      = {b, 8'h00};
          bytes_left_d = bytes_dec;
          phase_d      = PhIdl;
        end
        PhIdl: begin
          ident_d      = {ident_q[15:8], b};
          ident_vld_d  = 1'b1;
          bytes_left_d = bytes_dec;
          if (bytes_dec == '0) begin
            phase_d    = PhDone;
            res_vld_o  = 1'b1;
            res_o.kind = msp_pkg::KindDone;
          end else begin
            phase_d = PhCodes;
          end
        end
        PhCodes: begin
          if (codes_seen_q >= limit) begin
            phase_d      = PhDone;
            res_vld_o    = 1'b1;
            res_o.kind   = msp_pkg::KindErr;
            res_o.status = msp_pkg::StatusTooMany;
          end else begin
            codes_seen_d     = codes_seen_q + 8'd1;
            bytes_left_d     = bytes_dec;
            res_vld_o        = 1'b1;
            res_o.has_code   = 1'b1;
            res_o.code_value = b;
            res_o.code_index = codes_seen_q;
            if (bytes_dec == '0) begin
              phase_d    = PhDone;
              res_o.kind = msp_pkg::KindDone;
            end else begin
              res_o.kind = msp_pkg::KindCode;
            end
          end
        end
        default: ;
      endcase
    end

    // Every result reports the identifier and count as they stand after this byte.
    res_o.packet_ident = ident_vld_d ? ident_d : 16'h0000;
    res_o.code_count   = codes_seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      bytes_left_q <= '0;
      len_num_q    <= '0;
      ident_q      <= '0;
      ident_vld_q  <= 1'b0;
      codes_seen_q <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      len_num_q    <= len_num_d;
      ident_q      <= ident_d;
      ident_vld_q  <= ident_vld_d;
      codes_seen_q <= codes_seen_d;
    end
  end

endmodule

// File: rtl/mqtt_suback_parser_core.sv
// Top level of the SUBACK parser: input register, parser and result register.
// The parser takes one packet byte per beat and can accept a new byte in every
// cycle unless the output stalls. A byte is held in an input register and goes
// through the parser logic once the result register is free or being emptied.
// Its result, if any, is loaded into the result register at the end of that
// cycle. Bytes that give no result simply pass through without occupying
// the output. The input stalls only while a result waits in the output register
// and the sink does not take it. The max_codes register is written through the
// configuration channel, which is always ready, and should only be written
// while no byte is in flight.
module mqtt_suback_parser_core #(
  parameter int unsigned CodeCountLimit = msp_pkg::CodeCountLimitDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  msp_item_if.sink     item_i,
  msp_result_if.source result_o,
  msp_cfg_if.sink      cfg_i
);

  logic             in_vld_q;
  msp_pkg::item_t   in_q;
  logic             out_vld_q;
  msp_pkg::result_t out_q;
  logic [7:0]       max_codes_q;
  logic             advance;
  logic             res_vld;
  msp_pkg::result_t res;

  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || advance;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_codes_q <= msp_pkg::MaxCodesReset;
    end else if (cfg_i.valid) begin
      max_codes_q <= cfg_i.max_codes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_q.rx_byte      <= item_i.rx_byte;
      in_q.packet_start <= item_i.packet_start;
    end
  end

  msp_parse #(
    .CodeCountLimit(CodeCountLimit)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .max_codes_i(max_codes_q),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.kind         = out_q.kind;
  assign result_o.has_code     = out_q.has_code;
  assign result_o.code_value   = out_q.code_value;
  assign result_o.code_index   = out_q.code_index;
  assign result_o.status       = out_q.status;
  assign result_o.packet_ident = out_q.packet_ident;
  assign result_o.code_count   = out_q.code_count;

endmodule

// File: rtl/msp_checker.sv
// Port-level assertions for the SUBACK parser and their binding to the top level.
module msp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic        has_code_i,
  input logic [7:0]  code_value_i,
  input logic [7:0]  code_index_i,
  input logic [2:0]  status_i,
  input logic [7:0]  code_count_i
);

  // A result beat that is not taken stays offered, with kind, code and count unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(code_value_i)
      && $stable(code_index_i) && $stable(code_count_i))
    else $error("result changed while stalled");

  // Errors never carry a code.
  a_err_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == msp_pkg::KindErr |-> !has_code_i && code_value_i == 8'd0
      && code_index_i == 8'd0 && status_i != msp_pkg::StatusOk)
    else $error("error result carries a code");

  // A plain granted code is always a successful beat with a code.
  a_code_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == msp_pkg::KindCode |-> has_code_i
      && status_i == msp_pkg::StatusOk)
    else $error("granted code without code or with error status");

  // The count always includes the code just reported.
  a_count_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_code_i |-> code_count_i == code_index_i + 8'd1)
    else $error("code count does not follow code index");

endmodule

bind mqtt_suback_parser_core msp_checker u_msp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .kind_i      (result_o.kind),
  .has_code_i  (result_o.has_code),
  .code_value_i(result_o.code_value),
  .code_index_i(result_o.code_index),
  .status_i    (result_o.status),
  .code_count_i(result_o.code_count)
);

// File: bench/tb.sv
// Self-checking testbench for the SUBACK parser core: byte stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb;

  localparam int HoldCycles = 300;
  localparam int DrainCycles = 6;

  typedef enum logic [2:0] {
    PsIdle,
    PsLength,
    PsIdentHi,
    PsIdentLo,
    PsCodes,
    PsDone
  } parse_state_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  msp_item_if   item_if ();
  msp_result_if res_if ();
  msp_cfg_if    cfg_if ();

  mqtt_suback_parser_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // Predicted parser state and register copy.
  parse_state_e parse_st = PsIdle;
  logic [27:0]  bytes_remaining = '0;
  logic [1:0]   length_pos = '0;
  logic [15:0]  ident_reg = '0;
  logic         ident_known = 1'b0;
  logic [7:0]   codes_taken = '0;
  logic [7:0]   max_codes_reg = msp_pkg::MaxCodesReset;

  msp_pkg::result_t expected_results[$];
  int      mismatches = 0;
  int      bytes_parsed = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_seq = 0;

  // Advances the predicted parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output msp_pkg::result_t r);
    int unsigned limit;
    bit          emitted;
    r = '0;
    emitted = 1'b0;
    if (start) begin
      bytes_remaining = '0;
      length_pos = '0;
      ident_reg = '0;
      codes_taken = '0;
      ident_known = 1'b0;
      if (b[7:4] != msp_pkg::SubackType) begin
        parse_st = PsDone;
        r.kind = msp_pkg::KindErr;
        r.status = msp_pkg::StatusWrongType;
        return 1'b1;
      end
      parse_st = PsLength;
      return 1'b0;
    end
    case (parse_st)
      PsLength: begin
        bytes_remaining = bytes_remaining | (28'(b[6:0]) << (7 * length_pos));
        if (b[7]) begin
          if (length_pos == 2'd3) begin
            parse_st = PsDone;
            r.kind = msp_pkg::KindErr;
            r.status = msp_pkg::StatusLenMalf;
            emitted = 1'b1;
          end else begin
            length_pos = length_pos + 2'd1;
          end
        end else if (bytes_remaining < 28'd2) begin
          parse_st = PsDone;
          r.kind = msp_pkg::KindErr;
          r.status = msp_pkg::StatusLenShort;
          emitted = 1'b1;
        end else begin
          parse_st = PsIdentHi;
        end
      end
      PsIdentHi: begin
        ident_reg = {b, 8'h00};
        bytes_remaining = bytes_remaining - 28'd1;
        parse_st = PsIdentLo;
      end
      PsIdentLo: begin
        ident_reg = ident_reg | {8'h00, b};
        ident_known = 1'b1;
        bytes_remaining = bytes_remaining - 28'd1;
        if (bytes_remaining == '0) begin
          parse_st = PsDone;
          r.kind = msp_pkg::KindDone;
          emitted = 1'b1;
        end else begin
          parse_st = PsCodes;
        end
      end
      PsCodes: begin
        limit = max_codes_reg;
        if (msp_pkg::CodeCountLimitDef < limit) limit = msp_pkg::CodeCountLimitDef;
        if (codes_taken >= limit) begin
          parse_st = PsDone;
          r.kind = msp_pkg::KindErr;
          r.status = msp_pkg::StatusTooMany;
        end else begin
          r.has_code = 1'b1;
          r.code_value = b;
          r.code_index = codes_taken;
          codes_taken = codes_taken + 8'd1;
          bytes_remaining = bytes_remaining - 28'd1;
          if (bytes_remaining == '0) begin
            parse_st = PsDone;
            r.kind = msp_pkg::KindDone;
          end else begin
            r.kind = msp_pkg::KindCode;
          end
        end
        emitted = 1'b1;
      end
      default: ;
    endcase
    if (emitted) begin
      r.packet_ident = ident_known ? ident_reg : 16'h0000;
      r.code_count = codes_taken;
    end
    return emitted;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sends one byte, possibly after a few idle cycles, and predicts its result on acceptance.
  task automatic send_byte(input logic [7:0] b, input logic start);
    msp_pkg::result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.rx_byte <= b;
    item_if.packet_start <= start;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (start || (parse_st != PsIdle && parse_st != PsDone)) bytes_parsed++;
    if (parse_byte(b, start, r)) expected_results.push_back(r);
  endtask

  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // Bytes without a result may still be in the pipeline.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_codes(input logic [7:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.max_codes <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    max_codes_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Sends a well-formed SUBACK, optionally with a padded length field or cut short.
  task automatic send_packet(input int num_codes, input bit pad_length, input int cut);
    logic [7:0] body[$];
    int         total_len;
    int         groups;
    int         sent;
    int         i;
    total_len = num_codes + 2;
    groups = (total_len < 128) ? 1 : 2;
    if (pad_length) groups = groups + $urandom_range(4 - groups);
    for (i = 0; i < groups; i++) begin
      body.push_back({i != groups - 1, 7'(total_len >> (7 * i))});
    end
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    for (i = 0; i < num_codes; i++) body.push_back(8'($urandom));
    sent = (cut >= 0 && cut < body.size()) ? cut : body.size();
    send_byte({msp_pkg::SubackType, 4'($urandom)}, 1'b1);
    for (i = 0; i < sent; i++) send_byte(body[i], 1'b0);
  endtask

  task automatic test_idle_and_type();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h20, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_length_field();
    // Four continuation bytes in a row are one too many.
    send_byte(8'h90, 1'b1);
    repeat (4) send_byte(8'h80, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'h01, 1'b0);
    // A padded length that still decodes to zero.
    send_byte(8'h9F, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_short_packets();
    send_byte(8'h90, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h93, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h33, 1'b0);
  endtask

  task automatic test_code_limit();
    write_max_codes(8'd1);
    send_byte(8'h90, 1'b1);
    send_byte(8'h04, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    write_max_codes(8'd255);
    send_packet(255, 1'b0, -1);
    send_packet(256, 1'b0, -1);
    write_max_codes(8'd254);
    send_packet(255, 1'b0, -1);
  endtask

  task automatic test_backpressure();
    write_max_codes(8'd255);
    tx_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    send_packet(40, 1'b0, -1);
    wait_drained();
  endtask

  task automatic test_random(input int target, input int tx_pct, input int rx_pct);
    logic [7:0] cfg_choice[7];
    logic [7:0] hdr;
    int         goal;
    int         next_cfg;
    int         sel;
    int         num_codes;
    int         cut;
    cfg_choice = '{8'd0, 8'd1, 8'd2, 8'd4, 8'd254, 8'd255, 8'd0};
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    goal = bytes_parsed + target;
    next_cfg = bytes_parsed;
    while (bytes_parsed < goal) begin
      if (bytes_parsed >= next_cfg) begin
        cfg_choice[6] = 8'($urandom);
        write_max_codes(cfg_choice[$urandom_range(6)]);
        next_cfg = bytes_parsed + 110;
      end
      sel = $urandom_range(99);
      if (sel < 70) begin
        sel = $urandom_range(99);
        num_codes = (sel < 60) ? $urandom_range(4) :
                    (sel < 90) ? $urandom_range(20, 5) : $urandom_range(60, 21);
        cut = ($urandom_range(9) == 0) ? $urandom_range(num_codes + 4) : -1;
        send_packet(num_codes, $urandom_range(4) == 0, cut);
      end else if (sel < 80) begin
        hdr = 8'($urandom);
        if (hdr[7:4] == msp_pkg::SubackType && sel < 77) hdr[7] = ~hdr[7];
        send_byte(hdr, 1'b1);
        repeat ($urandom_range(3)) send_byte(8'($urandom), 1'b0);
      end else if (sel < 92) begin
        // Arbitrary length field, then whatever follows.
        send_byte({msp_pkg::SubackType, 4'($urandom)}, 1'b1);
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom), 1'b0);
        repeat ($urandom_range(6)) send_byte(8'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // Result ready: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin
    int hold_ack;
    int hold_left;
    hold_ack = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_ack) begin
        hold_ack = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    msp_pkg::result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, actual kind %0d status %0d",
                 $time, res_if.kind, res_if.status);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, res_if.kind);
        check_field("has_code", want.has_code, res_if.has_code);
        check_field("code_value", want.code_value, res_if.code_value);
        check_field("code_index", want.code_index, res_if.code_index);
        check_field("status", want.status, res_if.status);
        check_field("packet_ident", want.packet_ident, res_if.packet_ident);
        check_field("code_count", want.code_count, res_if.code_count);
      end
    end
  end

  initial begin
    item_if.valid <= 1'b0;
    item_if.rx_byte <= 8'h00;
    item_if.packet_start <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.max_codes <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 14;
    rx_idle_pct <= 55;
    test_idle_and_type();
    test_length_field();
    test_short_packets();
    test_code_limit();
    test_backpressure();
    test_random(210, 14, 55);
    test_random(210, 55, 14);
    test_random(210, 0, 0);
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/msp_pkg.sv
rtl/msp_if.sv
rtl/msp_parse.sv
rtl/mqtt_suback_parser_core.sv
rtl/msp_checker.sv
bench/tb.sv
